### hw/rtl/fdmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmd_pkg
// Shared types, register indexes and constants of the frame difference
// motion detector.
// ----------------------------------------------------------------------------
package fdmd_pkg;

  // Frame size limits, defaults for the top level parameters
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam int SIZE_W     = 12;
  localparam int THR_W      = 8;
  localparam int CNT_W      = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THRESHOLD = 2'd3;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST     = 12'd640;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST    = 12'd480;
  localparam logic [THR_W-1:0]  DIFF_THRESHOLD_RST  = 8'd20;
  localparam logic [CNT_W-1:0]  COUNT_THRESHOLD_RST = 23'd50000;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int          PIX_W       = 8;
  localparam logic [7:0]  PIX_CHANGED = 8'd255;

  localparam int QUAD_W = 3;
  localparam logic [QUAD_W-1:0] QUAD_NONE         = 3'd0;
  localparam logic [QUAD_W-1:0] QUAD_RIGHT_TOP    = 3'd1;
  localparam logic [QUAD_W-1:0] QUAD_RIGHT_BOTTOM = 3'd2;
  localparam logic [QUAD_W-1:0] QUAD_LEFT_BOTTOM  = 3'd3;
  localparam logic [QUAD_W-1:0] QUAD_LEFT_TOP     = 3'd4;

  localparam int CENT_W = 11;

  // Depth of the queue between front and back
  localparam int FIFO_DEPTH = 32;

  typedef struct packed {
    logic [PIX_W-1:0] old_pixel;
    logic [PIX_W-1:0] new_pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0]  display_pixel;
    logic              frame_done;
    logic              motion_found;
    logic [QUAD_W-1:0] quadrant;
    logic [CENT_W-1:0] centroid_x;
    logic [CENT_W-1:0] centroid_y;
  } out_t;

  // One classified pixel on its way from front to back
  typedef struct packed {
    logic [PIX_W-1:0] display_pixel;
    logic             frame_done;
  } rec_t;

endpackage

### hw/rtl/fdmd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmd_front
// Pixel classifier: position tracking, change test, running count and
// coordinate sums, and the end-of-frame snapshot for the back end.
// ----------------------------------------------------------------------------
module fdmd_front #(
  parameter int MAX_WIDTH  = fdmd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdmd_pkg::DEF_MAX_HEIGHT,
  localparam int CW   = $clog2(MAX_WIDTH),
  localparam int CH   = $clog2(MAX_HEIGHT),
  localparam int SUMW = $clog2(MAX_WIDTH * MAX_HEIGHT) + ((CW > CH) ? CW : CH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  fdmd_pkg::in_t                in_data,
  output logic                         full,
  input  logic [fdmd_pkg::SIZE_W-1:0]  frame_width,
  input  logic [fdmd_pkg::SIZE_W-1:0]  frame_height,
  input  logic [fdmd_pkg::THR_W-1:0]   diff_threshold,
  input  logic [fdmd_pkg::CNT_W-1:0]   count_threshold,
  input  logic                         q_full,
  output logic                         q_push,
  output fdmd_pkg::rec_t               q_data,
  input  logic                         snap_release,
  output logic                         snap_motion,
  output logic [fdmd_pkg::CNT_W-1:0]   snap_count,
  output logic [SUMW-1:0]              snap_sum_x,
  output logic [SUMW-1:0]              snap_sum_y,
  output logic [CW-1:0]                snap_half_w,
  output logic [CH-1:0]                snap_half_h
);

  localparam int WXW = ((CW > fdmd_pkg::SIZE_W) ? CW : fdmd_pkg::SIZE_W) + 1;
  localparam int WYW = ((CH > fdmd_pkg::SIZE_W) ? CH : fdmd_pkg::SIZE_W) + 1;

  logic [CW-1:0]              col_r;
  logic [CH-1:0]              row_r;
  logic [fdmd_pkg::CNT_W-1:0] cnt_r;
  logic [SUMW-1:0]            sum_x_r;
  logic [SUMW-1:0]            sum_y_r;
  logic                       busy_r;
  logic                       snap_motion_r;
  logic [fdmd_pkg::CNT_W-1:0] snap_count_r;
  logic [SUMW-1:0]            snap_sum_x_r;
  logic [SUMW-1:0]            snap_sum_y_r;
  logic [CW-1:0]              snap_half_w_r;
  logic [CH-1:0]              snap_half_h_r;

  logic [WXW-1:0]             w_eff;
  logic [WYW-1:0]             h_eff;
  logic                       last_col;
  logic                       last_row;
  logic                       last_pix;
  logic                       accept;
  logic [fdmd_pkg::PIX_W-1:0] abs_diff;
  logic                       changed;
  logic [fdmd_pkg::CNT_W-1:0] cnt_upd;
  logic [SUMW-1:0]            sum_x_upd;
  logic [SUMW-1:0]            sum_y_upd;

  // size zero acts as one, oversize acts as the limit
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WXW'(1);
    end else if (WXW'(frame_width) > WXW'(MAX_WIDTH)) begin
      w_eff = WXW'(MAX_WIDTH);
    end else begin
      w_eff = WXW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = WYW'(1);
    end else if (WYW'(frame_height) > WYW'(MAX_HEIGHT)) begin
      h_eff = WYW'(MAX_HEIGHT);
    end else begin
      h_eff = WYW'(frame_height);
    end
  end

  assign last_col = WXW'(col_r) >= (w_eff - WXW'(1));
  assign last_row = WYW'(row_r) >= (h_eff - WYW'(1));
  assign last_pix = last_col && last_row;

  // one frame-end snapshot: hold the frame's last pixel until it is free
  assign full   = q_full || (busy_r && last_pix);
  assign accept = push && !full;

  assign abs_diff = (in_data.old_pixel > in_data.new_pixel) ?
                    (in_data.old_pixel - in_data.new_pixel) :
                    (in_data.new_pixel - in_data.old_pixel);
  assign changed  = abs_diff > diff_threshold;

  always_comb begin
    cnt_upd   = cnt_r;
    sum_x_upd = sum_x_r;
    sum_y_upd = sum_y_r;
    if (changed) begin
      if (cnt_r != fdmd_pkg::CNT_MAX) begin
        cnt_upd = cnt_r + 1'b1;
      end
      sum_x_upd = sum_x_r + SUMW'(col_r);
      sum_y_upd = sum_y_r + SUMW'(row_r);
    end
  end

  assign q_push                = accept;
  assign q_data.display_pixel  = changed ? fdmd_pkg::PIX_CHANGED : in_data.new_pixel;
  assign q_data.frame_done     = last_pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      busy_r  <= 1'b0;
    end else begin
      if (snap_release) begin
        busy_r <= 1'b0;
      end
      if (accept) begin
        if (last_pix) begin
          col_r   <= '0;
          row_r   <= '0;
          cnt_r   <= '0;
          sum_x_r <= '0;
          sum_y_r <= '0;
          busy_r  <= 1'b1;
        end else begin
          cnt_r   <= cnt_upd;
          sum_x_r <= sum_x_upd;
          sum_y_r <= sum_y_upd;
          if (last_col) begin
            col_r <= '0;
            row_r <= CH'(row_r + 1'b1);
          end else begin
            col_r <= CW'(col_r + 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_pix) begin
      snap_motion_r <= cnt_upd > count_threshold;
      snap_count_r  <= cnt_upd;
      snap_sum_x_r  <= sum_x_upd;
      snap_sum_y_r  <= sum_y_upd;
      snap_half_w_r <= CW'(w_eff >> 1);
      snap_half_h_r <= CH'(h_eff >> 1);
    end
  end

  assign snap_motion = snap_motion_r;
  assign snap_count  = snap_count_r;
  assign snap_sum_x  = snap_sum_x_r;
  assign snap_sum_y  = snap_sum_y_r;
  assign snap_half_w = snap_half_w_r;
  assign snap_half_h = snap_half_h_r;

endmodule

### hw/rtl/fdmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmd_fifo
// Short request queue between the classifier and the back end.
// ----------------------------------------------------------------------------
module fdmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  fdmd_pkg::rec_t wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output fdmd_pkg::rec_t rd_data,
  output logic           q_empty
);

  localparam int AW = $clog2(fdmd_pkg::FIFO_DEPTH);

  fdmd_pkg::rec_t mem_r [fdmd_pkg::FIFO_DEPTH];
  fdmd_pkg::rec_t head_r;
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [AW:0]    count_r;
  logic [AW-1:0]  rd_nxt;
  logic           do_wr;
  logic           do_rd;

  assign q_full  = count_r == (AW+1)'(fdmd_pkg::FIFO_DEPTH);
  assign q_empty = count_r == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_nxt  = !do_rd ? rd_ptr_r :
                   (rd_ptr_r == AW'(fdmd_pkg::FIFO_DEPTH - 1)) ? '0 : AW'(rd_ptr_r + 1'b1);
  assign rd_data = head_r;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // registered head; a write into an otherwise empty queue goes straight through
  always_ff @(posedge clk) begin
    if (do_wr && (rd_nxt == wr_ptr_r)) begin
      head_r <= wr_data;
    end else begin
      head_r <= mem_r[rd_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(fdmd_pkg::FIFO_DEPTH - 1)) ? '0 : AW'(wr_ptr_r + 1'b1);
      end
      rd_ptr_r <= rd_nxt;
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/fdmd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmd_back
// Result stage: passes pixels to the output register and, on a frame with
// motion, works out quadrant and centroid with one restoring divider per axis.
// ----------------------------------------------------------------------------
module fdmd_back #(
  parameter int MAX_WIDTH  = fdmd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdmd_pkg::DEF_MAX_HEIGHT,
  localparam int CW   = $clog2(MAX_WIDTH),
  localparam int CH   = $clog2(MAX_HEIGHT),
  localparam int SUMW = $clog2(MAX_WIDTH * MAX_HEIGHT) + ((CW > CH) ? CW : CH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  fdmd_pkg::rec_t             q_head,
  output logic                       q_pop,
  input  logic                       snap_motion,
  input  logic [fdmd_pkg::CNT_W-1:0] snap_count,
  input  logic [SUMW-1:0]            snap_sum_x,
  input  logic [SUMW-1:0]            snap_sum_y,
  input  logic [CW-1:0]              snap_half_w,
  input  logic [CH-1:0]              snap_half_h,
  output logic                       snap_release,
  output fdmd_pkg::out_t             out_data,
  output logic                       empty,
  input  logic                       pop
);

  localparam int NW  = fdmd_pkg::CNT_W;
  localparam int PXW = CW + NW;
  localparam int PYW = CH + NW;
  localparam int XCW = (SUMW > PXW) ? SUMW : PXW;
  localparam int YCW = (SUMW > PYW) ? SUMW : PYW;
  localparam int ITW = $clog2(SUMW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]      state_r;
  logic [1:0]      state_nxt;
  logic [PXW-1:0]  hx_r;
  logic [PYW-1:0]  hy_r;
  logic [SUMW-1:0] qx_r;
  logic [SUMW-1:0] qy_r;
  logic [NW-1:0]   rx_r;
  logic [NW-1:0]   ry_r;
  logic [ITW-1:0]  iter_r;
  fdmd_pkg::out_t  out_r;
  logic            out_valid_r;

  logic            out_free;
  logic            load_pix;
  logic            load_frame;
  logic [NW:0]     rx_sh;
  logic [NW:0]     ry_sh;
  logic            x_ge;
  logic            y_ge;
  logic            gx;
  logic            lx;
  logic            gy;
  logic            ly;
  logic [fdmd_pkg::QUAD_W-1:0] quad;

  assign out_free = !out_valid_r || pop;

  always_comb begin
    state_nxt  = state_r;
    load_pix   = 1'b0;
    load_frame = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_head.frame_done && snap_motion) begin
            state_nxt = ST_MUL;
          end else if (out_free) begin
            load_pix = 1'b1;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (iter_r == ITW'(SUMW - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load_frame = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign q_pop        = load_pix || load_frame;
  assign snap_release = (load_pix && q_head.frame_done) || load_frame;

  // one restoring step per cycle, both axes side by side
  assign rx_sh = {rx_r, qx_r[SUMW-1]};
  assign ry_sh = {ry_r, qy_r[SUMW-1]};
  assign x_ge  = rx_sh >= {1'b0, snap_count};
  assign y_ge  = ry_sh >= {1'b0, snap_count};

  // exact mean against the centre lines by cross multiplication
  assign gx = XCW'(snap_sum_x) > XCW'(hx_r);
  assign lx = XCW'(snap_sum_x) < XCW'(hx_r);
  assign gy = YCW'(snap_sum_y) > YCW'(hy_r);
  assign ly = YCW'(snap_sum_y) < YCW'(hy_r);

  always_comb begin
    if (gx && ly) begin
      quad = fdmd_pkg::QUAD_RIGHT_TOP;
    end else if (gx && gy) begin
      quad = fdmd_pkg::QUAD_RIGHT_BOTTOM;
    end else if (lx && gy) begin
      quad = fdmd_pkg::QUAD_LEFT_BOTTOM;
    end else if (lx && ly) begin
      quad = fdmd_pkg::QUAD_LEFT_TOP;
    end else begin
      quad = fdmd_pkg::QUAD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_pix || load_frame) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      hx_r   <= PXW'(snap_half_w * snap_count);
      hy_r   <= PYW'(snap_half_h * snap_count);
      qx_r   <= snap_sum_x;
      qy_r   <= snap_sum_y;
      rx_r   <= '0;
      ry_r   <= '0;
      iter_r <= '0;
    end else if (state_r == ST_DIV) begin
      qx_r   <= {qx_r[SUMW-2:0], x_ge};
      qy_r   <= {qy_r[SUMW-2:0], y_ge};
      rx_r   <= x_ge ? NW'(rx_sh - {1'b0, snap_count}) : NW'(rx_sh);
      ry_r   <= y_ge ? NW'(ry_sh - {1'b0, snap_count}) : NW'(ry_sh);
      iter_r <= ITW'(iter_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_pix) begin
      out_r.display_pixel <= q_head.display_pixel;
      out_r.frame_done    <= q_head.frame_done;
      out_r.motion_found  <= 1'b0;
      out_r.quadrant      <= fdmd_pkg::QUAD_NONE;
      out_r.centroid_x    <= '0;
      out_r.centroid_y    <= '0;
    end else if (load_frame) begin
      out_r.display_pixel <= q_head.display_pixel;
      out_r.frame_done    <= 1'b1;
      out_r.motion_found  <= 1'b1;
      out_r.quadrant      <= quad;
      out_r.centroid_x    <= fdmd_pkg::CENT_W'(qx_r);
      out_r.centroid_y    <= fdmd_pkg::CENT_W'(qy_r);
    end
  end

  assign out_data = out_r;
  assign empty    = !out_valid_r;

endmodule

### hw/rtl/frame_difference_motion_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_difference_motion_detector_unit
// Frame differencing motion detector: marks changed pixels and reports
// motion, quadrant and centroid at the end of every frame.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                 Moves
//  -------   -----------------------------------   -----------------------------
//  input     push, full, in_data                   one pixel pair per request
//  result    pop, empty, out_data                  one result per pixel, in order
//  config    cfg_we, cfg_index, cfg_wdata          register write, no wait
//
//  Ordinary pixels run at one request per cycle while neither queue nor output
//  stalls; the classifier takes one pixel a cycle, the result stage moves one
//  a cycle into its output reg. A frame end with motion holds the result stage
//  in its per-axis restoring dividers over SUMW-bit sums (SUMW = 33 at the
//  default 2048 x 2048 limit); the classifier keeps taking next-frame pixels
//  into the 32-entry queue meanwhile, and only stalls when that queue fills or
//  a second frame end arrives before the first is reported.
//  Reset is synchronous, active low, and restores the register defaults.
//
module frame_difference_motion_detector_unit #(
  parameter int MAX_WIDTH  = fdmd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdmd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  fdmd_pkg::in_t                   in_data,
  output logic                            full,
  output fdmd_pkg::out_t                  out_data,
  output logic                            empty,
  input  logic                            pop,
  input  logic                            cfg_we,
  input  logic [fdmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CH   = $clog2(MAX_HEIGHT);
  localparam int SUMW = $clog2(MAX_WIDTH * MAX_HEIGHT) + ((CW > CH) ? CW : CH);

  // configuration registers
  logic [fdmd_pkg::SIZE_W-1:0] frame_width_r;
  logic [fdmd_pkg::SIZE_W-1:0] frame_height_r;
  logic [fdmd_pkg::THR_W-1:0]  diff_threshold_r;
  logic [fdmd_pkg::CNT_W-1:0]  count_threshold_r;

  // front to queue
  logic           q_push;
  fdmd_pkg::rec_t q_wdata;
  logic           q_full;
  // queue to back
  logic           q_pop;
  fdmd_pkg::rec_t q_head;
  logic           q_empty;

  // frame-end snapshot
  logic                       snap_motion;
  logic [fdmd_pkg::CNT_W-1:0] snap_count;
  logic [SUMW-1:0]            snap_sum_x;
  logic [SUMW-1:0]            snap_sum_y;
  logic [CW-1:0]              snap_half_w;
  logic [CH-1:0]              snap_half_h;
  logic                       snap_release;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r     <= fdmd_pkg::FRAME_WIDTH_RST;
      frame_height_r    <= fdmd_pkg::FRAME_HEIGHT_RST;
      diff_threshold_r  <= fdmd_pkg::DIFF_THRESHOLD_RST;
      count_threshold_r <= fdmd_pkg::COUNT_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdmd_pkg::CFG_FRAME_WIDTH: begin
          frame_width_r <= cfg_wdata[fdmd_pkg::SIZE_W-1:0];
        end
        fdmd_pkg::CFG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_wdata[fdmd_pkg::SIZE_W-1:0];
        end
        fdmd_pkg::CFG_DIFF_THRESHOLD: begin
          diff_threshold_r <= cfg_wdata[fdmd_pkg::THR_W-1:0];
        end
        fdmd_pkg::CFG_COUNT_THRESHOLD: begin
          count_threshold_r <= cfg_wdata[fdmd_pkg::CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // classifier: position, change test, running sums
  fdmd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .in_data         (in_data),
    .full            (full),
    .frame_width     (frame_width_r),
    .frame_height    (frame_height_r),
    .diff_threshold  (diff_threshold_r),
    .count_threshold (count_threshold_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata),
    .snap_release    (snap_release),
    .snap_motion     (snap_motion),
    .snap_count      (snap_count),
    .snap_sum_x      (snap_sum_x),
    .snap_sum_y      (snap_sum_y),
    .snap_half_w     (snap_half_w),
    .snap_half_h     (snap_half_h)
  );

  // decouples pixel intake from the end-of-frame divide
  fdmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_empty (q_empty)
  );

  // result stage with divider and output register
  fdmd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .snap_motion  (snap_motion),
    .snap_count   (snap_count),
    .snap_sum_x   (snap_sum_x),
    .snap_sum_y   (snap_sum_y),
    .snap_half_w  (snap_half_w),
    .snap_half_h  (snap_half_h),
    .snap_release (snap_release),
    .out_data     (out_data),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame difference motion detector. Pixel pairs
// go in through a queue-style push port and every result coming out is
// checked field by field against an in-bench model of the classifier,
// the frame counters and the end-of-frame centroid and quadrant logic.
// Frame size and thresholds are rewritten between runs of pixels.
// ----------------------------------------------------------------------------
module tb;

  logic                            clk;
  logic                            rst_n;
  logic                            push = 1'b0;
  fdmd_pkg::in_t                   in_data = '0;
  logic                            full;
  fdmd_pkg::out_t                  out_data;
  logic                            empty;
  logic                            pop = 1'b0;
  logic                            cfg_we;
  logic [fdmd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fdmd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  frame_difference_motion_detector_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .out_data  (out_data),
    .empty     (empty),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Pixel pairs waiting for the driver, and results the model says are due.
  fdmd_pkg::in_t  pixel_pairs[$];
  fdmd_pkg::out_t due_results[$];

  int   pairs_queued = 0;   // touched by the stimulus process only
  int   pairs_taken  = 0;   // touched at the rising edge only
  bit   pair_taken   = 1'b0;
  int   mismatches   = 0;

  // Idle control. Rates are "one burst per N requests", 0 means never.
  // Rates and hold_send are written at rising edges, read by the driver at falling edges.
  int   send_idle_rate = 0;
  int   pop_idle_rate  = 0;
  bit   hold_send      = 1'b0;
  int   send_gap       = 0;
  int   pop_stall      = 0;

  // --------------------------------------------------------------------------
  // Model state: registers as the block should hold them, plus the running
  // position, changed count and coordinate sums of the current frame.
  // --------------------------------------------------------------------------
  logic [fdmd_pkg::SIZE_W-1:0] frame_w_reg;
  logic [fdmd_pkg::SIZE_W-1:0] frame_h_reg;
  logic [fdmd_pkg::THR_W-1:0]  diff_thr_reg;
  logic [fdmd_pkg::CNT_W-1:0]  count_thr_reg;

  int unsigned       col_pos;
  int unsigned       row_pos;
  int unsigned       chg_count;
  longint unsigned   col_sum;
  longint unsigned   row_sum;

  // Zero acts as one, anything past the build limit acts as the limit.
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void clear_frame_sums();
    col_pos   = 0;
    row_pos   = 0;
    chg_count = 0;
    col_sum   = 0;
    row_sum   = 0;
  endfunction

  // Classify one pixel pair, advance the frame position and, on the frame's
  // last pixel, work out motion, quadrant and centroid.
  function automatic fdmd_pkg::out_t classify_pixel(input fdmd_pkg::in_t px);
    int unsigned     w;
    int unsigned     h;
    int unsigned     diff;
    longint unsigned half_x;
    longint unsigned half_y;
    bit              last_col;
    bit              last_row;
    fdmd_pkg::out_t  r;

    w = clamp_dim(32'(frame_w_reg), fdmd_pkg::DEF_MAX_WIDTH);
    h = clamp_dim(32'(frame_h_reg), fdmd_pkg::DEF_MAX_HEIGHT);
    r = '0;
    r.display_pixel = px.new_pixel;

    if (px.old_pixel > px.new_pixel)
      diff = int'(px.old_pixel) - int'(px.new_pixel);
    else
      diff = int'(px.new_pixel) - int'(px.old_pixel);

    if (diff > diff_thr_reg) begin
      r.display_pixel = fdmd_pkg::PIX_CHANGED;
      if (chg_count < fdmd_pkg::CNT_MAX)
        chg_count++;
      col_sum += col_pos;
      row_sum += row_pos;
    end

    // Counters beyond the last index (size shrunk mid-frame) end the row too.
    last_col = (col_pos >= w - 1);
    last_row = (row_pos >= h - 1);

    if (last_col && last_row) begin
      r.frame_done = 1'b1;
      if (chg_count > count_thr_reg) begin
        half_x = longint'(w / 2) * chg_count;
        half_y = longint'(h / 2) * chg_count;
        r.motion_found = 1'b1;
        r.centroid_x   = fdmd_pkg::CENT_W'(col_sum / chg_count);
        r.centroid_y   = fdmd_pkg::CENT_W'(row_sum / chg_count);
        if (col_sum > half_x && row_sum < half_y)
          r.quadrant = fdmd_pkg::QUAD_RIGHT_TOP;
        else if (col_sum > half_x && row_sum > half_y)
          r.quadrant = fdmd_pkg::QUAD_RIGHT_BOTTOM;
        else if (col_sum < half_x && row_sum > half_y)
          r.quadrant = fdmd_pkg::QUAD_LEFT_BOTTOM;
        else if (col_sum < half_x && row_sum < half_y)
          r.quadrant = fdmd_pkg::QUAD_LEFT_TOP;
        else
          r.quadrant = fdmd_pkg::QUAD_NONE;  // centroid sits on a centre line
      end
      clear_frame_sums();
    end else if (last_col) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  // One line per mismatch, and a count.
  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: runs at the rising edge. Mirrors register writes into the
  // model, runs the model on every accepted request and checks every
  // accepted result against the oldest one due. Checking comes first so a
  // result never meets an expectation queued on the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    fdmd_pkg::out_t due;
    if (!rst_n) begin
      frame_w_reg   = fdmd_pkg::FRAME_WIDTH_RST;
      frame_h_reg   = fdmd_pkg::FRAME_HEIGHT_RST;
      diff_thr_reg  = fdmd_pkg::DIFF_THRESHOLD_RST;
      count_thr_reg = fdmd_pkg::COUNT_THRESHOLD_RST;
      clear_frame_sums();
      pair_taken = 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due", 64'(out_data), 64'(0));
        end else begin
          due = due_results.pop_front();
          if (out_data.display_pixel !== due.display_pixel)
            report_mismatch("display_pixel", 64'(out_data.display_pixel),
                            64'(due.display_pixel));
          if (out_data.frame_done !== due.frame_done)
            report_mismatch("frame_done", 64'(out_data.frame_done),
                            64'(due.frame_done));
          if (out_data.motion_found !== due.motion_found)
            report_mismatch("motion_found", 64'(out_data.motion_found),
                            64'(due.motion_found));
          if (out_data.quadrant !== due.quadrant)
            report_mismatch("quadrant", 64'(out_data.quadrant), 64'(due.quadrant));
          if (out_data.centroid_x !== due.centroid_x)
            report_mismatch("centroid_x", 64'(out_data.centroid_x),
                            64'(due.centroid_x));
          if (out_data.centroid_y !== due.centroid_y)
            report_mismatch("centroid_y", 64'(out_data.centroid_y),
                            64'(due.centroid_y));
        end
      end

      // Register writes only happen while the block is idle, so they never
      // share an edge with a request.
      if (cfg_we) begin
        case (cfg_index)
          fdmd_pkg::CFG_FRAME_WIDTH:     frame_w_reg   = cfg_wdata[fdmd_pkg::SIZE_W-1:0];
          fdmd_pkg::CFG_FRAME_HEIGHT:    frame_h_reg   = cfg_wdata[fdmd_pkg::SIZE_W-1:0];
          fdmd_pkg::CFG_DIFF_THRESHOLD:  diff_thr_reg  = cfg_wdata[fdmd_pkg::THR_W-1:0];
          fdmd_pkg::CFG_COUNT_THRESHOLD: count_thr_reg = cfg_wdata[fdmd_pkg::CNT_W-1:0];
          default: ;
        endcase
      end

      pair_taken = push && !full;
      if (pair_taken) begin
        due_results.push_back(classify_pixel(in_data));
        pairs_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: runs at the falling edge. A request stays up with its data until
  // it is taken; idle bursts are started at random right after a request is
  // issued. The result side stalls pop the same way.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (!push || pair_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (!hold_send && pixel_pairs.size() != 0) begin
          in_data <= pixel_pairs.pop_front();
          push    <= 1'b1;
          if (send_idle_rate != 0 && $urandom_range(1, send_idle_rate) == 1)
            send_gap = $urandom_range(1, 3);
        end else begin
          push <= 1'b0;
        end
      end

      if (pop_stall > 0) begin
        pop_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (pop_idle_rate != 0 && $urandom_range(1, pop_idle_rate) == 1)
          pop_stall = $urandom_range(1, 3);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Every request has exactly one result, so once all queued pairs are taken
  // and nothing is due the block holds no work at all.
  task automatic wait_idle();
    do @(negedge clk);
    while (pairs_taken != pairs_queued || due_results.size() != 0);
  endtask

  task automatic write_reg(input logic [fdmd_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= fdmd_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Pairs and idle rates are changed at a rising edge so the driver never
  // races with them.
  task automatic start_phase(input int send_rate, input int pop_rate);
    @(posedge clk);
    send_idle_rate = send_rate;
    pop_idle_rate  = pop_rate;
  endtask

  task automatic queue_pair(input logic [fdmd_pkg::PIX_W-1:0] old_px,
                            input logic [fdmd_pkg::PIX_W-1:0] new_px);
    fdmd_pkg::in_t p;
    p.old_pixel = old_px;
    p.new_pixel = new_px;
    pixel_pairs.push_back(p);
    pairs_queued++;
  endtask

  // New pixel is either unrelated, near the old one (straddles typical
  // thresholds), equal, or the inverse.
  task automatic queue_random_pairs(input int n);
    int o;
    int v;
    repeat (n) begin
      o = $urandom_range(0, 255);
      case ($urandom_range(0, 3))
        0:       v = $urandom_range(0, 255);
        1:       v = o + $urandom_range(0, 60) - 30;
        2:       v = o;
        default: v = 255 - o;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      queue_pair(fdmd_pkg::PIX_W'(o), fdmd_pkg::PIX_W'(v));
    end
  endtask

  task automatic pick_rate(output int r);
    r = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(3, 8);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned wv;
    int unsigned hv;
    int unsigned we;
    int unsigned he;
    int unsigned cv;
    int          n;
    int          s_rate;
    int          p_rate;
    int          random_pairs;
    int          phase_no;
    int          mark;

    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Zero sizes act as a 1x1 frame: every pixel ends a frame. With both
    // thresholds at zero any nonzero difference is motion, and a lone
    // changed pixel at (0,0) sits on both centre lines.
    write_reg(fdmd_pkg::CFG_FRAME_WIDTH, 0);
    write_reg(fdmd_pkg::CFG_FRAME_HEIGHT, 0);
    write_reg(fdmd_pkg::CFG_DIFF_THRESHOLD, 0);
    write_reg(fdmd_pkg::CFG_COUNT_THRESHOLD, 0);
    start_phase(4, 4);
    queue_pair(8'd0, 8'd0);
    queue_pair(8'd0, 8'd255);
    queue_pair(8'd255, 8'd0);
    queue_pair(8'd255, 8'd255);
    queue_pair(8'd1, 8'd0);

    // Threshold at its top: nothing can ever count as changed.
    wait_idle();
    write_reg(fdmd_pkg::CFG_FRAME_WIDTH, 2);
    write_reg(fdmd_pkg::CFG_FRAME_HEIGHT, 2);
    write_reg(fdmd_pkg::CFG_DIFF_THRESHOLD, 255);
    start_phase(4, 4);
    repeat (4) queue_pair(8'd0, 8'd255);

    // 4x4 frame with one change at the top right corner.
    wait_idle();
    write_reg(fdmd_pkg::CFG_FRAME_WIDTH, 4);
    write_reg(fdmd_pkg::CFG_FRAME_HEIGHT, 4);
    write_reg(fdmd_pkg::CFG_DIFF_THRESHOLD, 20);
    start_phase(0, 0);
    for (int i = 0; i < 16; i++)
      queue_pair(8'd100, (i == 3) ? 8'd200 : 8'd105);

    // Oversized width clamps to the limit; shrinking it mid-row makes the
    // next pixel end the row, and with one row, the frame.
    wait_idle();
    write_reg(fdmd_pkg::CFG_FRAME_WIDTH, (1 << fdmd_pkg::SIZE_W) - 1);
    write_reg(fdmd_pkg::CFG_FRAME_HEIGHT, fdmd_pkg::DEF_MAX_HEIGHT);
    write_reg(fdmd_pkg::CFG_DIFF_THRESHOLD, 10);
    write_reg(fdmd_pkg::CFG_COUNT_THRESHOLD, 2);
    start_phase(4, 4);
    queue_random_pairs(40);
    wait_idle();
    write_reg(fdmd_pkg::CFG_FRAME_WIDTH, 3);
    write_reg(fdmd_pkg::CFG_FRAME_HEIGHT, 1);
    start_phase(4, 4);
    queue_random_pairs(6);

    // Same for the row counter, with a count threshold no frame can beat.
    wait_idle();
    write_reg(fdmd_pkg::CFG_FRAME_WIDTH, 1);
    write_reg(fdmd_pkg::CFG_FRAME_HEIGHT, (1 << fdmd_pkg::SIZE_W) - 1);
    write_reg(fdmd_pkg::CFG_COUNT_THRESHOLD, (1 << fdmd_pkg::CNT_W) - 1);
    start_phase(4, 4);
    queue_random_pairs(30);
    wait_idle();
    write_reg(fdmd_pkg::CFG_FRAME_HEIGHT, 2);
    start_phase(4, 4);
    queue_random_pairs(4);

    // Random phases: mostly tiny frames so frame ends, motion and every
    // quadrant come often. A phase may stop mid-frame, so the next setting
    // also resizes frames in flight.
    random_pairs = 0;
    phase_no     = 0;
    while (random_pairs < 1150) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       wv = 0;
        1:       wv = ($urandom_range(0, 5) == 0) ? fdmd_pkg::DEF_MAX_WIDTH :
                      $urandom_range(7, 40);
        default: wv = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0:       hv = 0;
        1:       hv = $urandom_range(6, 20);
        default: hv = $urandom_range(1, 5);
      endcase
      we = clamp_dim(wv, fdmd_pkg::DEF_MAX_WIDTH);
      he = clamp_dim(hv, fdmd_pkg::DEF_MAX_HEIGHT);
      case ($urandom_range(0, 5))
        0:       cv = 0;
        1:       cv = $urandom_range(0, fdmd_pkg::CNT_MAX);
        default: cv = $urandom_range(0, we * he);
      endcase
      write_reg(fdmd_pkg::CFG_FRAME_WIDTH, wv);
      write_reg(fdmd_pkg::CFG_FRAME_HEIGHT, hv);
      case ($urandom_range(0, 7))
        0:       write_reg(fdmd_pkg::CFG_DIFF_THRESHOLD, 0);
        1:       write_reg(fdmd_pkg::CFG_DIFF_THRESHOLD, $urandom_range(0, 255));
        default: write_reg(fdmd_pkg::CFG_DIFF_THRESHOLD, $urandom_range(0, 60));
      endcase
      write_reg(fdmd_pkg::CFG_COUNT_THRESHOLD, cv);

      n = $urandom_range(30, 120);
      pick_rate(s_rate);
      pick_rate(p_rate);
      start_phase(s_rate, p_rate);
      mark = pairs_queued;
      queue_random_pairs(n);

      // Once, the sender holds back mid-phase until the block has drained.
      if (phase_no == 3) begin
        do @(negedge clk);
        while (pairs_taken < mark + n / 2);
        @(posedge clk) hold_send = 1'b1;
        do @(negedge clk);
        while (push || due_results.size() != 0);
        @(posedge clk) hold_send = 1'b0;
      end

      random_pairs += n;
      phase_no++;
    end

    // Closing stretch at full rate on both sides.
    wait_idle();
    write_reg(fdmd_pkg::CFG_FRAME_WIDTH, $urandom_range(2, 5));
    write_reg(fdmd_pkg::CFG_FRAME_HEIGHT, $urandom_range(2, 4));
    write_reg(fdmd_pkg::CFG_DIFF_THRESHOLD, $urandom_range(5, 40));
    write_reg(fdmd_pkg::CFG_COUNT_THRESHOLD, $urandom_range(0, 3));
    start_phase(0, 0);
    queue_random_pairs(150);

    // Drain, then give the divider time to show any stray result.
    wait_idle();
    repeat (64) @(posedge clk);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  // Worst case is far below this: every pair a motion frame end through the
  // divider, plus both sides' longest idle bursts.
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
